@@ design/sha1s_pkg.sv @@
`timescale 1ns / 1ps
package sha1s_pkg;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       end_of_message;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    typedef enum logic [1:0] {
        K_NONE,
        K_BYTE,
        K_END,
        K_BYTE_END
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_out_t;

    typedef enum logic [2:0] {
        ST_ABSORB,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } back_state_t;

    typedef enum logic [1:0] {
        RET_ABSORB,
        RET_PAD,
        RET_EMIT
    } ret_t;

    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK        = 8'h80;
    localparam logic [6:0] LAST_ROUND      = 7'd79;
    localparam logic [5:0] BLOCK_LAST_BYTE = 6'd63;
    localparam logic [5:0] LEN_START       = 6'd56;
    localparam logic [2:0] LAST_WORD_IDX   = 3'd4;

    function automatic kind_t classify(input byte_item_t it);
        kind_t k;
        case ({it.byte_present, it.end_of_message})
            2'b10:   k = K_BYTE;
            2'b01:   k = K_END;
            2'b11:   k = K_BYTE_END;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] j);
        logic [31:0] k;
        if (j < 7'd20)
            k = K_0;
        else if (j < 7'd40)
            k = K_1;
        else if (j < 7'd60)
            k = K_2;
        else
            k = K_3;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] j, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (j < 7'd20)
            f = (b & c) | (~b & d);
        else if (j < 7'd40 || j >= 7'd60)
            f = b ^ c ^ d;
        else
            f = (b & c) | (b & d) | (c & d);
        return f;
    endfunction

endpackage

@@ design/sha1s_front.sv @@
`timescale 1ns / 1ps
module sha1s_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  sha1s_pkg::byte_item_t byte_item,
    output sha1s_pkg::q_out_t     qo,
    input  logic                  pop
);
    import sha1s_pkg::*;

    localparam int QDepth = 2;
    localparam int PtrW   = $clog2(QDepth);
    localparam int CntW   = $clog2(QDepth + 1);

    q_entry_t          entry_reg [QDepth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [CntW-1:0]   count_reg;
    kind_t             kind;
    logic              push;
    logic              do_pop;

    assign byte_stall = (count_reg == CntW'(QDepth));
    assign kind       = classify(byte_item);
    // drop requests that carry neither a byte nor an end marker
    assign push       = byte_valid && !byte_stall && (kind != K_NONE);
    assign do_pop     = pop && (count_reg != '0);

    assign qo.valid       = (count_reg != '0);
    assign qo.entry       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg].kind <= kind;
            entry_reg[wr_ptr_reg].data <= byte_item.message_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ design/sha1s_back.sv @@
`timescale 1ns / 1ps
module sha1s_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sha1s_pkg::q_out_t       qo,
    output logic                    pop,
    output logic                    digest_valid,
    input  logic                    digest_stall,
    output sha1s_pkg::digest_item_t digest_item
);
    import sha1s_pkg::*;

    back_state_t  state_reg, state_next;
    ret_t         ret_reg, ret_next;
    logic [5:0]   bc_reg, bc_next;
    logic [63:0]  bits_reg, bits_next;
    logic         mark_reg, mark_next;
    logic         len_reg, len_next;
    logic [6:0]   round_reg, round_next;
    logic [2:0]   emit_reg, emit_next;
    logic [31:0]  chain_reg [5];
    logic [31:0]  chain_next [5];
    logic [31:0]  vars_reg [5];
    logic [31:0]  vars_next [5];
    logic [23:0]  acc_reg, acc_next;
    logic [31:0]  sched_reg [16];
    logic [31:0]  sched_next [16];
    logic         out_valid_reg, out_valid_next;
    digest_item_t out_item_reg, out_item_next;

    logic         put_en;
    logic [7:0]   put_val;
    logic [63:0]  len_shift;
    logic [31:0]  sched_x;
    logic [31:0]  sched_new;
    logic [31:0]  round_t;
    logic         has_byte;
    logic         has_end;

    assign digest_valid = out_valid_reg;
    assign digest_item  = out_item_reg;

    assign len_shift = bits_reg << {bc_reg[2:0], 3'b000};
    assign sched_x   = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
    assign sched_new = {sched_x[30:0], sched_x[31]};
    assign round_t   = {vars_reg[0][26:0], vars_reg[0][31:27]}
                     + round_f(round_reg, vars_reg[1], vars_reg[2], vars_reg[3])
                     + vars_reg[4] + round_k(round_reg) + sched_reg[0];
    assign has_byte  = (qo.entry.kind == K_BYTE) || (qo.entry.kind == K_BYTE_END);
    assign has_end   = (qo.entry.kind == K_END) || (qo.entry.kind == K_BYTE_END);

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        bc_next        = bc_reg;
        bits_next      = bits_reg;
        mark_next      = mark_reg;
        len_next       = len_reg;
        round_next     = round_reg;
        emit_next      = emit_reg;
        chain_next     = chain_reg;
        vars_next      = vars_reg;
        acc_next       = acc_reg;
        sched_next     = sched_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        pop            = 1'b0;
        put_en         = 1'b0;
        put_val        = 8'h00;

        if (out_valid_reg && !digest_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_ABSORB:
            begin
                if (qo.valid)
                begin
                    pop = 1'b1;
                    if (has_byte)
                    begin
                        put_en    = 1'b1;
                        put_val   = qo.entry.data;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (has_byte && bc_reg == BLOCK_LAST_BYTE)
                    begin
                        state_next = ST_ROUND;
                        ret_next   = has_end ? RET_PAD : RET_ABSORB;
                        round_next = '0;
                        for (int i = 0; i < 5; i++)
                            vars_next[i] = chain_reg[i];
                    end
                    else if (has_end)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                put_en = 1'b1;
                if (!mark_reg)
                begin
                    put_val   = PAD_MARK;
                    mark_next = 1'b1;
                end
                else if (len_reg || bc_reg == LEN_START)
                begin
                    put_val  = len_shift[63:56];
                    len_next = 1'b1;
                end
                if (bc_reg == BLOCK_LAST_BYTE)
                begin
                    state_next = ST_ROUND;
                    ret_next   = len_reg ? RET_EMIT : RET_PAD;
                    round_next = '0;
                    for (int i = 0; i < 5; i++)
                        vars_next[i] = chain_reg[i];
                end
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                    sched_next[i] = sched_reg[i + 1];
                sched_next[15] = sched_new;
                vars_next[0]   = round_t;
                vars_next[1]   = vars_reg[0];
                vars_next[2]   = {vars_reg[1][1:0], vars_reg[1][31:2]};
                vars_next[3]   = vars_reg[2];
                vars_next[4]   = vars_reg[3];
                round_next     = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                for (int i = 0; i < 5; i++)
                    chain_next[i] = chain_reg[i] + vars_reg[i];
                case (ret_reg)
                    RET_PAD:  state_next = ST_PAD;
                    RET_EMIT: state_next = ST_EMIT;
                    default:  state_next = ST_ABSORB;
                endcase
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !digest_stall)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.digest_word = chain_reg[emit_reg];
                    out_item_next.word_index  = emit_reg;
                    out_item_next.last_word   = (emit_reg == LAST_WORD_IDX);
                    emit_next                 = emit_reg + 3'd1;
                    if (emit_reg == LAST_WORD_IDX)
                    begin
                        // start over for the next message
                        emit_next  = '0;
                        bits_next  = '0;
                        mark_next  = 1'b0;
                        len_next   = 1'b0;
                        state_next = ST_ABSORB;
                        for (int i = 0; i < 5; i++)
                            chain_next[i] = H_INIT[i];
                    end
                end
            end
            default:
            begin
                state_next = ST_ABSORB;
            end
        endcase

        // pack bytes big-endian; a finished word enters the schedule line
        if (put_en)
        begin
            acc_next = {acc_reg[15:0], put_val};
            bc_next  = bc_reg + 6'd1;
            if (bc_reg[1:0] == 2'b11)
            begin
                for (int i = 0; i < 15; i++)
                    sched_next[i] = sched_reg[i + 1];
                sched_next[15] = {acc_reg, put_val};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ABSORB;
            ret_reg       <= RET_ABSORB;
            bc_reg        <= '0;
            bits_reg      <= '0;
            mark_reg      <= 1'b0;
            len_reg       <= 1'b0;
            round_reg     <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 5; i++)
                chain_reg[i] <= H_INIT[i];
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            bc_reg        <= bc_next;
            bits_reg      <= bits_next;
            mark_reg      <= mark_next;
            len_reg       <= len_next;
            round_reg     <= round_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vars_reg     <= vars_next;
        acc_reg      <= acc_next;
        sched_reg    <= sched_next;
        out_item_reg <= out_item_next;
    end

endmodule

@@ design/sha1_stream_hasher.sv @@
`timescale 1ns / 1ps
// Channel   Valid          Stall          Payload
// byte      byte_valid     byte_stall     byte_item   (message_byte, byte_present, end_of_message)
// digest    digest_valid   digest_stall   digest_item (digest_word, word_index, last_word)
//
// Each data byte goes through the packer; a full 64-byte block then runs the 80 rounds
// of the single round unit and a fold into the chain words.
// An end marker without a byte is popped on its own; finishing then adds the padding
// bytes (9 to 72), the rounds and fold of each final block (one or two), and the
// emission of the five digest words.
// Reset loads the initial chain words and clears all counters; no clearing pass.
// A two-deep request queue absorbs input while the back end compresses; the digest
// register holds a word under stall; only after the last word does the back end absorb again.
module sha1_stream_hasher (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_valid,
    output logic                    byte_stall,
    input  sha1s_pkg::byte_item_t   byte_item,
    output logic                    digest_valid,
    input  logic                    digest_stall,
    output sha1s_pkg::digest_item_t digest_item
);
    import sha1s_pkg::*;

    q_out_t qo;
    logic   pop;

    sha1s_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .qo         (qo),
        .pop        (pop)
    );

    sha1s_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qo           (qo),
        .pop          (pop),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_item  (digest_item)
    );

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> qo.valid)
        else $error("back end popped an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n) qo.valid |-> qo.entry.kind != K_NONE)
        else $error("empty request reached the queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_item.last_word |-> digest_item.word_index == LAST_WORD_IDX)
        else $error("last digest word at wrong index");

endmodule
